// ===== src/eracu_pkg.sv =====
// Package for the event rate activity classifier.
// Holds level codes, opcodes and register indexes; no dependencies.
package eracu_pkg;
  typedef logic [1:0] level_t;
  localparam level_t LVL_QUIET  = 2'd0;
  localparam level_t LVL_NORMAL = 2'd1;
  localparam level_t LVL_BUSY   = 2'd2;
  localparam level_t LVL_SPIKE  = 2'd3;

  localparam logic [1:0] OP_FIRST  = 2'd0;
  localparam logic [1:0] OP_SECOND = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_SPARE  = 2'd3;

  localparam logic [2:0] REG_WINDOW   = 3'd0;
  localparam logic [2:0] REG_HOLD     = 3'd1;
  localparam logic [2:0] REG_COOLDOWN = 3'd2;
  localparam logic [2:0] REG_SPIKE    = 3'd3;
  localparam logic [2:0] REG_BUSY     = 3'd4;
  localparam logic [2:0] REG_QUIET    = 3'd5;
  localparam logic [2:0] REG_APPLY    = 3'd6;
endpackage

// ===== src/event_rate_activity_classifier_unit.sv =====
// Event rate activity classifier: two stamp rings, window count, level FSM.
// Depends on eracu_pkg.
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/in_stall | opcode, now_ms, sighting_count
//  out_    | output    | out_valid/out_stall | level ... second_total
//  cfg_    | input     | cfg_we           | cfg_index, cfg_data
//
// A batch writes one stamp a cycle, min(n,RING_DEPTH) stamps in all.
// A tick walks both rings in parallel, one entry a cycle through the RAM read
// port, then compares against the spike, busy and quiet thresholds in turn
// through one shared 20x12 multiplier/comparator.
// Reset is synchronous; the rings need no clearing. A stalled result holds,
// and in_stall is high while busy or while a result waits.
module event_rate_activity_classifier_unit #(
  parameter int RING_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_now_ms,
  input  logic [15:0] in_sighting_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_level,
  output logic [1:0]  out_interval_profile,
  output logic        out_level_changed,
  output logic [$clog2(RING_DEPTH):0] out_first_window_count,
  output logic [$clog2(RING_DEPTH):0] out_second_window_count,
  output logic [31:0] out_change_count,
  output logic [31:0] out_first_total,
  output logic [31:0] out_second_total,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_WRITE, S_WALK, S_CMP, S_APPLY, S_OUT
  } state_t;
  state_t state_r;

  logic [31:0] ram_a [RING_DEPTH];
  logic [31:0] ram_b [RING_DEPTH];
  logic [31:0] rd_a_r, rd_b_r;

  logic [11:0] win_r;
  logic [31:0] hold_r, cool_r;
  logic [19:0] spk_r, bsy_r, qut_r;
  logic        apply_r;

  logic [AW-1:0] head_a_r, head_b_r;
  logic [CW-1:0] fill_a_r, fill_b_r;
  logic [31:0]   sum_a_r, sum_b_r;
  eracu_pkg::level_t lvl_r, prof_r;
  logic [31:0] entered_r, exit_r, changes_r;
  logic        exit_v_r;

  logic [1:0]  op_r;
  logic [31:0] now_r, cut_r;
  logic [CW-1:0] wcnt_r, cnt_a_r, cnt_b_r;
  logic        run_a_r, run_b_r, rdv_r;
  logic [AW-1:0] ptr_r;
  logic [1:0]  cstep_r;
  logic        ge_spk_r, ge_bsy_r, le_qut_r;
  logic        changed_r;

  // shared unit: c*K vs T*W (or c*16 vs T)
  logic [CW:0]  csum;
  logic [19:0]  thr;
  logic [43:0]  lhs, rhs;
  assign csum = {1'b0, cnt_a_r} + {1'b0, cnt_b_r};
  always_comb begin
    unique case (cstep_r)
      2'd0: thr = spk_r;
      2'd1: thr = bsy_r;
      default: thr = qut_r;
    endcase
    if (win_r == 12'd0) begin
      lhs = 44'(csum) << 4;
      rhs = 44'(thr);
    end else begin
      lhs = 44'(csum) * 44'd960;
      rhs = 44'(thr) * 44'(win_r);
    end
  end

  logic [31:0] win_ms;
  assign win_ms = 32'(win_r) * 32'd1000;

  logic [CW-1:0] wcnt_dec;
  assign wcnt_dec = wcnt_r - CW'(1);

  eracu_pkg::level_t cand;
  always_comb begin
    priority if (ge_spk_r) cand = eracu_pkg::LVL_SPIKE;
    else if (ge_bsy_r) cand = eracu_pkg::LVL_BUSY;
    else if (le_qut_r) cand = eracu_pkg::LVL_QUIET;
    else cand = eracu_pkg::LVL_NORMAL;
  end

  assign in_stall = (state_r != S_IDLE);

  // ring memories
  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) begin
      if (op_r == eracu_pkg::OP_FIRST) ram_a[head_a_r] <= now_r;
      else ram_b[head_b_r] <= now_r;
    end
    rd_a_r <= ram_a[head_a_r - ptr_r - AW'(1)];
    rd_b_r <= ram_b[head_b_r - ptr_r - AW'(1)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      win_r <= 12'd60; hold_r <= 32'd10000; cool_r <= 32'd30000;
      spk_r <= 20'd960; bsy_r <= 20'd480; qut_r <= 20'd80; apply_r <= 1'b1;
      head_a_r <= '0; head_b_r <= '0; fill_a_r <= '0; fill_b_r <= '0;
      sum_a_r <= '0; sum_b_r <= '0;
      lvl_r <= eracu_pkg::LVL_NORMAL; prof_r <= eracu_pkg::LVL_NORMAL;
      entered_r <= '0; exit_r <= '0; exit_v_r <= 1'b0; changes_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          eracu_pkg::REG_WINDOW:   win_r <= cfg_data[11:0];
          eracu_pkg::REG_HOLD:     hold_r <= cfg_data;
          eracu_pkg::REG_COOLDOWN: cool_r <= cfg_data;
          eracu_pkg::REG_SPIKE:    spk_r <= cfg_data[19:0];
          eracu_pkg::REG_BUSY:     bsy_r <= cfg_data[19:0];
          eracu_pkg::REG_QUIET:    qut_r <= cfg_data[19:0];
          eracu_pkg::REG_APPLY:    apply_r <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r <= in_opcode;
            now_r <= in_now_ms;
            ptr_r <= '0;
            wcnt_r <= (in_sighting_count > 16'(RING_DEPTH)) ? DEPTH_C
                      : CW'(in_sighting_count);
            cut_r <= (in_now_ms > win_ms) ? in_now_ms - win_ms : 32'd0;
            if ((in_opcode == eracu_pkg::OP_FIRST ||
                 in_opcode == eracu_pkg::OP_SECOND) && in_sighting_count != 16'd0) begin
              if (in_opcode == eracu_pkg::OP_FIRST)
                sum_a_r <= sum_a_r + 32'(in_sighting_count);
              else
                sum_b_r <= sum_b_r + 32'(in_sighting_count);
              state_r <= S_WRITE;
            end else if (in_opcode == eracu_pkg::OP_TICK) begin
              cnt_a_r <= '0; cnt_b_r <= '0;
              run_a_r <= 1'b1; run_b_r <= 1'b1; rdv_r <= 1'b0;
              state_r <= S_WALK;
            end
          end
        end
        S_WRITE: begin
          // one stamp a cycle, fill saturates at depth
          if (op_r == eracu_pkg::OP_FIRST) begin
            head_a_r <= head_a_r + AW'(1);
            if (fill_a_r != DEPTH_C) fill_a_r <= fill_a_r + CW'(1);
          end else begin
            head_b_r <= head_b_r + AW'(1);
            if (fill_b_r != DEPTH_C) fill_b_r <= fill_b_r + CW'(1);
          end
          wcnt_r <= wcnt_dec;
          if (wcnt_dec == '0) state_r <= S_IDLE;
        end
        S_WALK: begin
          // read data is registered, so it trails the pointer
          rdv_r <= 1'b1;
          if (ptr_r != AW'(RING_DEPTH - 1)) ptr_r <= ptr_r + AW'(1);
          if (rdv_r) begin
            if (run_a_r) begin
              if (cnt_a_r < fill_a_r && rd_a_r >= cut_r) cnt_a_r <= cnt_a_r + CW'(1);
              else run_a_r <= 1'b0;
            end
            if (run_b_r) begin
              if (cnt_b_r < fill_b_r && rd_b_r >= cut_r) cnt_b_r <= cnt_b_r + CW'(1);
              else run_b_r <= 1'b0;
            end
            if ((!run_a_r || cnt_a_r == DEPTH_C) && (!run_b_r || cnt_b_r == DEPTH_C)) begin
              cstep_r <= 2'd0;
              state_r <= S_CMP;
            end
          end
        end
        S_CMP: begin
          unique case (cstep_r)
            2'd0: ge_spk_r <= (lhs >= rhs);
            2'd1: ge_bsy_r <= (lhs >= rhs);
            default: le_qut_r <= (lhs <= rhs);
          endcase
          cstep_r <= cstep_r + 2'd1;
          if (cstep_r == 2'd2) state_r <= S_APPLY;
        end
        S_APPLY: begin
          changed_r <= 1'b0;
          if (!((now_r - entered_r) < hold_r && cand != eracu_pkg::LVL_SPIKE)) begin
            eracu_pkg::level_t c2;
            c2 = (cand == eracu_pkg::LVL_SPIKE && exit_v_r && (now_r - exit_r) < cool_r)
                 ? eracu_pkg::LVL_BUSY : cand;
            if (c2 != lvl_r) begin
              if (lvl_r == eracu_pkg::LVL_SPIKE && c2 != eracu_pkg::LVL_SPIKE) begin
                exit_r <= now_r; exit_v_r <= 1'b1;
              end
              lvl_r <= c2;
              entered_r <= now_r;
              changes_r <= changes_r + 32'd1;
              if (apply_r) prof_r <= c2;
              changed_r <= 1'b1;
            end
          end
          out_valid <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_level = lvl_r;
  assign out_interval_profile = prof_r;
  assign out_level_changed = changed_r;
  assign out_first_window_count = cnt_a_r;
  assign out_second_window_count = cnt_b_r;
  assign out_change_count = changes_r;
  assign out_first_total = sum_a_r;
  assign out_second_total = sum_b_r;
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for event_rate_activity_classifier_unit.
// Uses eracu_pkg for level codes, opcodes and register indexes. A directed
// list is followed by random traffic; every tick result is compared with a
// local model of the stamp rings and the level state machine.
`timescale 1ns / 100ps

module testbench;

  localparam int DEPTH      = 256;
  localparam int WD_LIMIT   = 20000;
  localparam int SETTLE     = 300;
  localparam int N_PHASES   = 8;
  localparam int PER_PHASE  = 190;

  typedef struct {
    eracu_pkg::level_t level;
    eracu_pkg::level_t profile;
    logic        changed;
    logic [8:0]  first_cnt;
    logic [8:0]  second_cnt;
    logic [31:0] changes;
    logic [31:0] first_total;
    logic [31:0] second_total;
  } tick_result_t;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] now;
    logic [15:0] cnt;
    bit          typed;
    eracu_pkg::level_t level;
    eracu_pkg::level_t profile;
    logic        changed;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [31:0] in_now_ms;
  logic [15:0] in_sighting_count;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_level;
  logic [1:0]  out_interval_profile;
  logic        out_level_changed;
  logic [8:0]  out_first_window_count;
  logic [8:0]  out_second_window_count;
  logic [31:0] out_change_count;
  logic [31:0] out_first_total;
  logic [31:0] out_second_total;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  event_rate_activity_classifier_unit u_dut (.*);

  // Local copy of the classifier state
  logic [31:0] first_stamps [DEPTH];
  logic [31:0] second_stamps [DEPTH];
  int unsigned first_head, second_head, first_fill, second_fill;
  logic [31:0] first_sum, second_sum;
  logic [11:0] win_s;
  logic [31:0] hold_ms, cool_ms;
  logic [19:0] spike_thr, busy_thr, quiet_thr;
  logic        apply_en;
  eracu_pkg::level_t cur_level, cur_profile;
  logic [31:0] entered_ms, spike_exit_ms, change_total;
  bit          spike_exit_seen;

  tick_result_t pending_results[$];
  int          errors;
  bit          calm;
  int          idle_cycles;
  logic [31:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void model_reset();
    first_head = 0; second_head = 0; first_fill = 0; second_fill = 0;
    first_sum = '0; second_sum = '0;
    win_s = 12'd60; hold_ms = 32'd10000; cool_ms = 32'd30000;
    spike_thr = 20'd960; busy_thr = 20'd480; quiet_thr = 20'd80; apply_en = 1'b1;
    cur_level = eracu_pkg::LVL_NORMAL; cur_profile = eracu_pkg::LVL_NORMAL;
    entered_ms = '0; spike_exit_ms = '0; spike_exit_seen = 1'b0; change_total = '0;
  endfunction

  function automatic void model_config(logic [2:0] idx, logic [31:0] val);
    case (idx)
      eracu_pkg::REG_WINDOW:   win_s = val[11:0];
      eracu_pkg::REG_HOLD:     hold_ms = val;
      eracu_pkg::REG_COOLDOWN: cool_ms = val;
      eracu_pkg::REG_SPIKE:    spike_thr = val[19:0];
      eracu_pkg::REG_BUSY:     busy_thr = val[19:0];
      eracu_pkg::REG_QUIET:    quiet_thr = val[19:0];
      eracu_pkg::REG_APPLY:    apply_en = val[0];
      default: ;
    endcase
  endfunction

  function automatic bit rate_at_least(longint unsigned c, longint unsigned t);
    if (win_s == 0) return c * 16 >= t;
    return c * 960 >= t * win_s;
  endfunction

  function automatic bit rate_at_most(longint unsigned c, longint unsigned t);
    if (win_s == 0) return c * 16 <= t;
    return c * 960 <= t * win_s;
  endfunction

  // Count stamps newest-first until one falls below the cutoff
  function automatic int unsigned count_recent(bit second, logic [31:0] cutoff);
    int unsigned n;
    int unsigned fill;
    int unsigned head;
    logic [31:0] stamp;
    n = 0;
    fill = second ? second_fill : first_fill;
    head = second ? second_head : first_head;
    for (int unsigned i = 0; i < fill; i++) begin
      stamp = second ? second_stamps[(head + DEPTH - 1 - i) % DEPTH]
                     : first_stamps[(head + DEPTH - 1 - i) % DEPTH];
      if (stamp < cutoff) break;
      n++;
    end
    return n;
  endfunction

  // Advance the model by one request; push a result for a tick
  function automatic void classify_request(logic [1:0] op, logic [31:0] now,
                                           logic [15:0] n);
    int unsigned m;
    logic [31:0] span_ms, cutoff;
    int unsigned c1, c2;
    longint unsigned c;
    eracu_pkg::level_t cand;
    bit changed;
    tick_result_t r;
    if (op == eracu_pkg::OP_FIRST || op == eracu_pkg::OP_SECOND) begin
      if (n == 0) return;
      m = (n < DEPTH) ? n : DEPTH;
      for (int unsigned i = 0; i < m; i++) begin
        if (op == eracu_pkg::OP_FIRST) begin
          first_stamps[first_head] = now;
          first_head = (first_head + 1) % DEPTH;
        end else begin
          second_stamps[second_head] = now;
          second_head = (second_head + 1) % DEPTH;
        end
      end
      if (op == eracu_pkg::OP_FIRST) begin
        first_fill = (first_fill + m > DEPTH) ? DEPTH : first_fill + m;
        first_sum += 32'(n);
      end else begin
        second_fill = (second_fill + m > DEPTH) ? DEPTH : second_fill + m;
        second_sum += 32'(n);
      end
      return;
    end
    if (op != eracu_pkg::OP_TICK) return;
    span_ms = 32'(win_s) * 32'd1000;
    cutoff = (now > span_ms) ? now - span_ms : 32'd0;
    c1 = count_recent(1'b0, cutoff);
    c2 = count_recent(1'b1, cutoff);
    c = c1 + c2;
    if (rate_at_least(c, spike_thr)) cand = eracu_pkg::LVL_SPIKE;
    else if (rate_at_least(c, busy_thr)) cand = eracu_pkg::LVL_BUSY;
    else if (rate_at_most(c, quiet_thr)) cand = eracu_pkg::LVL_QUIET;
    else cand = eracu_pkg::LVL_NORMAL;
    changed = 1'b0;
    if (!(now - entered_ms < hold_ms && cand != eracu_pkg::LVL_SPIKE)) begin
      // a spike soon after leaving spike is downgraded
      if (cand == eracu_pkg::LVL_SPIKE && spike_exit_seen && now - spike_exit_ms < cool_ms)
        cand = eracu_pkg::LVL_BUSY;
      if (cand != cur_level) begin
        if (cur_level == eracu_pkg::LVL_SPIKE) begin
          spike_exit_ms = now;
          spike_exit_seen = 1'b1;
        end
        cur_level = cand;
        entered_ms = now;
        change_total++;
        if (apply_en) cur_profile = cand;
        changed = 1'b1;
      end
    end
    r.level = cur_level;
    r.profile = cur_profile;
    r.changed = changed;
    r.first_cnt = 9'(c1);
    r.second_cnt = 9'(c2);
    r.changes = change_total;
    r.first_total = first_sum;
    r.second_total = second_sum;
    pending_results.push_back(r);
  endfunction

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic send_request(logic [1:0] op, logic [31:0] now, logic [15:0] n);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_now_ms <= now;
    in_sighting_count <= n;
    do @(posedge clk); while (in_stall);
    classify_request(op, now, n);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // a batch may still be writing stamps after the last result
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    model_config(idx, val);
  endtask

  task automatic configure(int phase);
    logic [31:0] v [7];
    case (phase)
      1: v = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
      2: v = '{32'd3600, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hF_FFFF, 32'hF_FFFF,
               32'hF_FFFF, 32'd1};
      default: v = '{$urandom_range(0, 120), $urandom_range(0, 20000),
                     $urandom_range(0, 60000), $urandom_range(0, 2000),
                     $urandom_range(0, 1000), $urandom_range(0, 200),
                     $urandom_range(0, 1)};
    endcase
    write_reg(eracu_pkg::REG_WINDOW, v[0]);
    write_reg(eracu_pkg::REG_HOLD, v[1]);
    write_reg(eracu_pkg::REG_COOLDOWN, v[2]);
    write_reg(eracu_pkg::REG_SPIKE, v[3]);
    write_reg(eracu_pkg::REG_BUSY, v[4]);
    write_reg(eracu_pkg::REG_QUIET, v[5]);
    write_reg(eracu_pkg::REG_APPLY, v[6]);
    cfg_we <= 1'b0;
  endtask

  task automatic random_request();
    int sel;
    logic [1:0] op;
    logic [15:0] n;
    sel = $urandom_range(0, 99);
    if (sel < 35) op = eracu_pkg::OP_FIRST;
    else if (sel < 70) op = eracu_pkg::OP_SECOND;
    else if (sel < 97) op = eracu_pkg::OP_TICK;
    else op = eracu_pkg::OP_SPARE;
    sel = $urandom_range(0, 99);
    if (sel < 70) n = 16'($urandom_range(1, 8));
    else if (sel < 85) n = 16'($urandom_range(0, 300));
    else if (sel < 95) n = 16'($urandom_range(0, 65535));
    else n = 16'd0;
    // mostly small steps, now and then a long jump
    if ($urandom_range(0, 49) == 0) clock_ms += $urandom_range(0, 32'h00FF_FFFF);
    else clock_ms += $urandom_range(0, 3000);
    send_request(op, clock_ms, n);
  endtask

  stim_row_t rows [] = '{
    '{eracu_pkg::OP_TICK,   32'd0,         16'd0,     1'b1,
      eracu_pkg::LVL_NORMAL, eracu_pkg::LVL_NORMAL, 1'b0},
    '{eracu_pkg::OP_FIRST,  32'd100,       16'd0,     1'b0,
      eracu_pkg::LVL_NORMAL, eracu_pkg::LVL_NORMAL, 1'b0},
    '{eracu_pkg::OP_FIRST,  32'd200,       16'd65535, 1'b0,
      eracu_pkg::LVL_NORMAL, eracu_pkg::LVL_NORMAL, 1'b0},
    '{eracu_pkg::OP_SECOND, 32'd300,       16'd1,     1'b0,
      eracu_pkg::LVL_NORMAL, eracu_pkg::LVL_NORMAL, 1'b0},
    '{eracu_pkg::OP_TICK,   32'd500,       16'd0,     1'b1,
      eracu_pkg::LVL_SPIKE,  eracu_pkg::LVL_SPIKE,  1'b1},
    '{eracu_pkg::OP_SPARE,  32'd600,       16'd5,     1'b0,
      eracu_pkg::LVL_NORMAL, eracu_pkg::LVL_NORMAL, 1'b0},
    '{eracu_pkg::OP_TICK,   32'd20000,     16'd0,     1'b1,
      eracu_pkg::LVL_SPIKE,  eracu_pkg::LVL_SPIKE,  1'b0},
    '{eracu_pkg::OP_TICK,   32'd70000,     16'd0,     1'b1,
      eracu_pkg::LVL_QUIET,  eracu_pkg::LVL_QUIET,  1'b1},
    '{eracu_pkg::OP_FIRST,  32'd71000,     16'd100,   1'b0,
      eracu_pkg::LVL_NORMAL, eracu_pkg::LVL_NORMAL, 1'b0},
    '{eracu_pkg::OP_TICK,   32'd72000,     16'd0,     1'b1,
      eracu_pkg::LVL_BUSY,   eracu_pkg::LVL_BUSY,   1'b1},
    '{eracu_pkg::OP_SECOND, 32'd90000,     16'd40,    1'b0,
      eracu_pkg::LVL_NORMAL, eracu_pkg::LVL_NORMAL, 1'b0},
    '{eracu_pkg::OP_TICK,   32'd95000,     16'd0,     1'b0,
      eracu_pkg::LVL_NORMAL, eracu_pkg::LVL_NORMAL, 1'b0},
    '{eracu_pkg::OP_TICK,   32'd200000,    16'd0,     1'b0,
      eracu_pkg::LVL_NORMAL, eracu_pkg::LVL_NORMAL, 1'b0},
    '{eracu_pkg::OP_SECOND, 32'hFFFF_FFFF, 16'd255,   1'b0,
      eracu_pkg::LVL_NORMAL, eracu_pkg::LVL_NORMAL, 1'b0},
    '{eracu_pkg::OP_FIRST,  32'hFFFF_FFFF, 16'd256,   1'b0,
      eracu_pkg::LVL_NORMAL, eracu_pkg::LVL_NORMAL, 1'b0},
    '{eracu_pkg::OP_TICK,   32'hFFFF_FFFF, 16'd0,     1'b0,
      eracu_pkg::LVL_NORMAL, eracu_pkg::LVL_NORMAL, 1'b0},
    '{eracu_pkg::OP_FIRST,  32'd5,         16'd257,   1'b0,
      eracu_pkg::LVL_NORMAL, eracu_pkg::LVL_NORMAL, 1'b0},
    '{eracu_pkg::OP_TICK,   32'd10,        16'd0,     1'b0,
      eracu_pkg::LVL_NORMAL, eracu_pkg::LVL_NORMAL, 1'b0}
  };

  // Result side: random stall after each accepted result
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) stall_left = draw_wait();
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    tick_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_level !== e.level) begin
          $error("level exp %0d got %0d", e.level, out_level); errors++;
        end
        if (out_interval_profile !== e.profile) begin
          $error("interval_profile exp %0d got %0d", e.profile, out_interval_profile);
          errors++;
        end
        if (out_level_changed !== e.changed) begin
          $error("level_changed exp %0d got %0d", e.changed, out_level_changed);
          errors++;
        end
        if (out_first_window_count !== e.first_cnt) begin
          $error("first_window_count exp %0d got %0d", e.first_cnt,
                 out_first_window_count);
          errors++;
        end
        if (out_second_window_count !== e.second_cnt) begin
          $error("second_window_count exp %0d got %0d", e.second_cnt,
                 out_second_window_count);
          errors++;
        end
        if (out_change_count !== e.changes) begin
          $error("change_count exp %0d got %0d", e.changes, out_change_count);
          errors++;
        end
        if (out_first_total !== e.first_total) begin
          $error("first_total exp %0d got %0d", e.first_total, out_first_total);
          errors++;
        end
        if (out_second_total !== e.second_total) begin
          $error("second_total exp %0d got %0d", e.second_total, out_second_total);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int pause_at;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = eracu_pkg::OP_FIRST;
    in_now_ms = '0;
    in_sighting_count = '0;
    cfg_we = 1'b0;
    cfg_index = eracu_pkg::REG_WINDOW;
    cfg_data = '0;
    errors = 0;
    calm = 1'b0;
    idle_cycles = 0;
    model_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      send_request(rows[i].op, rows[i].now, rows[i].cnt);
      // hold the typed-in fields over the model's for the obvious rows
      if (rows[i].typed) begin
        pending_results[$].level = rows[i].level;
        pending_results[$].profile = rows[i].profile;
        pending_results[$].changed = rows[i].changed;
      end
    end
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) configure(p);
      if (p == 5) clock_ms = 32'hFFFF_0000;
      else if (p == 0) clock_ms = 32'd300000;
      calm = (p % 3 == 2);
      pause_at = $urandom_range(20, PER_PHASE - 20);
      for (int k = 0; k < PER_PHASE; k++) begin
        if (k == pause_at) begin
          in_valid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
        random_request();
      end
      drain();
    end

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
